// ----- rtl/rar_pkg.sv -----
//------------------------------------------------------------------------------
// Rational arithmetic package
// Shared types and codes for the rational arithmetic reduction block.
//------------------------------------------------------------------------------
`default_nettype none
package rar_pkg;

  typedef enum logic [1:0] {
    ACT_ADD = 2'd0,
    ACT_SUB = 2'd1,
    ACT_MUL = 2'd2,
    ACT_DIV = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ZERO  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // classified work item between front and back
  typedef struct packed {
    logic        err;      // zero denominator or divisor
    logic        neg;      // result sign
    logic [62:0] mn;       // numerator magnitude
    logic [62:0] md;       // denominator magnitude
  } job_t;

  typedef struct packed {
    logic [31:0] res_num;
    logic [30:0] res_den;
    status_t     status;
  } res_t;

  typedef enum logic [2:0] {
    FS_IDLE,
    FS_MUL,
    FS_SUM,
    FS_PUSH
  } fstate_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_GCD,
    BS_DIV,
    BS_OUT
  } bstate_t;

endpackage
`default_nettype wire

// ----- rtl/rar_front.sv -----
//------------------------------------------------------------------------------
// Rational arithmetic front end
// Accepts items, forms the cross products and signs, pushes a job.
//------------------------------------------------------------------------------
`default_nettype none
module rar_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   action,
  input  wire logic [31:0]  a_num,
  input  wire logic [30:0]  a_den,
  input  wire logic [31:0]  b_num,
  input  wire logic [30:0]  b_den,
  output logic              job_valid,
  input  wire logic         job_ready,
  output rar_pkg::job_t     job
);

  rar_pkg::fstate_t state, state_next;
  logic [1:0]  act;
  logic [31:0] an, bn;
  logic [30:0] ad, bd;
  logic signed [63:0] p0, p1, pd;
  logic signed [64:0] num;
  logic        err;
  logic        nneg, dneg;
  logic signed [63:0] dsgn;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rar_pkg::FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    job_valid  = 1'b0;
    unique case (state)
      rar_pkg::FS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = rar_pkg::FS_MUL;
      end
      rar_pkg::FS_MUL:  state_next = rar_pkg::FS_SUM;
      rar_pkg::FS_SUM:  state_next = rar_pkg::FS_PUSH;
      rar_pkg::FS_PUSH: begin
        job_valid = 1'b1;
        if (job_ready) state_next = rar_pkg::FS_IDLE;
      end
      default: state_next = rar_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == rar_pkg::FS_IDLE && in_valid) begin
      act <= action;
      an  <= a_num;
      ad  <= a_den;
      bn  <= b_num;
      bd  <= b_den;
      err <= (a_den == '0) || (b_den == '0) ||
             (action == rar_pkg::ACT_DIV && b_num == '0);
    end
    // one 32x32 product per operand pair, registered
    if (state == rar_pkg::FS_MUL) begin
      p0 <= (act == rar_pkg::ACT_MUL) ? $signed(an) * $signed(bn)
                                       : $signed(an) * $signed({1'b0, bd});
      p1 <= $signed(bn) * $signed({1'b0, ad});
      pd <= (act == rar_pkg::ACT_DIV) ? $signed({1'b0, ad}) * $signed(bn)
                                       : $signed({1'b0, ad}) * $signed({1'b0, bd});
    end
    if (state == rar_pkg::FS_SUM) begin
      job.err <= err;
      job.neg <= nneg ^ dneg;
      job.mn  <= nneg ? 63'(-num) : num[62:0];
      job.md  <= dneg ? 63'(-dsgn) : dsgn[62:0];
    end
  end

  always_comb begin
    unique case (act)
      rar_pkg::ACT_ADD: num = 65'(p0) + 65'(p1);
      rar_pkg::ACT_SUB: num = 65'(p0) - 65'(p1);
      default:          num = 65'(p0);
    endcase
    dsgn = pd;
    nneg = num[64];
    dneg = pd[63];
  end

endmodule
`default_nettype wire

// ----- rtl/rar_fifo.sv -----
//------------------------------------------------------------------------------
// Rational arithmetic job queue
// Two-entry queue between front end and reduction engine.
//------------------------------------------------------------------------------
`default_nettype none
module rar_fifo (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      wr_valid,
  output logic           wr_ready,
  input  rar_pkg::job_t  wr_data,
  output logic           rd_valid,
  input  wire logic      rd_ready,
  output rar_pkg::job_t  rd_data
);

  rar_pkg::job_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       wr, rd;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr) wp <= ~wp;
      if (rd) rp <= ~rp;
      cnt <= cnt + {1'b0, wr} - {1'b0, rd};
    end
    if (wr) mem[wp] <= wr_data;
  end

endmodule
`default_nettype wire

// ----- rtl/rar_back.sv -----
//------------------------------------------------------------------------------
// Rational arithmetic back end
// Takes jobs from the queue and runs them through the reduction engine.
//------------------------------------------------------------------------------
`default_nettype none
module rar_back (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      job_valid,
  output logic           job_ready,
  input  rar_pkg::job_t  job,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rar_pkg::res_t  res
);

  rar_redux u_redux (
    .clk, .rst,
    .job_valid, .job_ready, .job,
    .out_valid, .out_ready, .res
  );

endmodule
`default_nettype wire

// ----- rtl/rational_arith_reduce_top.sv -----
//------------------------------------------------------------------------------
// Rational arithmetic with reduction to lowest terms
//  channel | dir | payload
//  s_axis  | in  | tdata: action, a_num, a_den, b_num, b_den
//  m_axis  | out | tdata: res_num, res_den, status
// The front end steps through its multiply, sum and push states after accept
// and takes a new word once its job is in the queue, so only while the queue
// has room. The back end then runs binary GCD steps, the divisions by the GCD
// and an output state; an error or zero result goes straight from accept to
// the output state.
// Reset rst is synchronous and clears all control state.
// A stalled m_axis holds its word and the back end waits.
//------------------------------------------------------------------------------
`default_nettype none
module rational_arith_reduce_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [1:0] action, [33:2] a_num, [64:34] a_den, [96:65] b_num, [127:97] b_den
  input  wire logic [127:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] res_num, [62:32] res_den, [64:63] status
  output logic [71:0]       m_axis_tdata
);

  logic          fj_valid, fj_ready, bj_valid, bj_ready;
  rar_pkg::job_t fj, bj;
  rar_pkg::res_t res;

  rar_front u_front (
    .clk, .rst,
    .in_valid (s_axis_tvalid), .in_ready (s_axis_tready),
    .action   (s_axis_tdata[1:0]),
    .a_num    (s_axis_tdata[33:2]),
    .a_den    (s_axis_tdata[64:34]),
    .b_num    (s_axis_tdata[96:65]),
    .b_den    (s_axis_tdata[127:97]),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  rar_fifo u_fifo (
    .clk, .rst,
    .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  rar_back u_back (
    .clk, .rst,
    .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {7'd0, res.status, res.res_den, res.res_num};

endmodule
`default_nettype wire

// ----- rtl/rar_redux.sv -----
//------------------------------------------------------------------------------
// Rational arithmetic reduction engine
// Binary GCD, divisions by the GCD, range check and output register.
//------------------------------------------------------------------------------
`default_nettype none
module rar_redux (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      job_valid,
  output logic           job_ready,
  input  rar_pkg::job_t  job,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rar_pkg::res_t  res
);

  rar_pkg::bstate_t state, state_next;
  logic [62:0] u, v, g, qn, qd, rn, rd, mn, md;
  logic [5:0]  k, bit_i;
  logic        neg;
  logic [63:0] rn_sh, rd_sh;
  rar_pkg::res_t fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rar_pkg::BS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_ready  = 1'b0;
    out_valid  = 1'b0;
    unique case (state)
      rar_pkg::BS_IDLE: begin
        job_ready = 1'b1;
        if (job_valid) begin
          if (job.err || job.mn == '0) state_next = rar_pkg::BS_OUT;
          else                         state_next = rar_pkg::BS_GCD;
        end
      end
      rar_pkg::BS_GCD: if (u == v) state_next = rar_pkg::BS_DIV;
      rar_pkg::BS_DIV: if (bit_i == 6'd0) state_next = rar_pkg::BS_OUT;
      rar_pkg::BS_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = rar_pkg::BS_IDLE;
      end
      default: state_next = rar_pkg::BS_IDLE;
    endcase
  end

  assign rn_sh = {rn, mn[bit_i]};
  assign rd_sh = {rd, md[bit_i]};

  // range check on the finished quotients
  always_comb begin
    logic [62:0] fqn, fqd;
    fqn = {qn[61:0], (rn_sh >= {1'b0, g})};
    fqd = {qd[61:0], (rd_sh >= {1'b0, g})};
    fin.res_num = '0;
    fin.res_den = '0;
    fin.status  = rar_pkg::ST_OK;
    if (fqd > 63'h7FFF_FFFF ||
        (neg && fqn > 63'h8000_0000) ||
        (!neg && fqn > 63'h7FFF_FFFF)) begin
      fin.status = rar_pkg::ST_RANGE;
    end else begin
      fin.res_num = neg ? 32'(~fqn[31:0] + 32'd1) : fqn[31:0];
      fin.res_den = fqd[30:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      rar_pkg::BS_IDLE: if (job_valid) begin
        mn  <= job.mn;
        md  <= job.md;
        neg <= job.neg;
        u   <= job.mn;
        v   <= job.md;
        k   <= '0;
        res.res_num <= '0;
        res.res_den <= job.err ? 31'd0 : 31'd1;
        res.status  <= job.err ? rar_pkg::ST_ZERO : rar_pkg::ST_OK;
      end
      // one binary GCD step a cycle
      rar_pkg::BS_GCD: begin
        if (u == v) begin
          g     <= u << k;
          bit_i <= 6'd62;
          rn    <= '0;
          rd    <= '0;
          qn    <= '0;
          qd    <= '0;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + 6'd1;
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (u > v) begin
          u <= (u - v) >> 1;
        end else begin
          v <= (v - u) >> 1;
        end
      end
      // one quotient bit of both divisions a cycle
      rar_pkg::BS_DIV: begin
        if (rn_sh >= {1'b0, g}) begin
          rn <= 63'(rn_sh - {1'b0, g});
          qn <= {qn[61:0], 1'b1};
        end else begin
          rn <= rn_sh[62:0];
          qn <= {qn[61:0], 1'b0};
        end
        if (rd_sh >= {1'b0, g}) begin
          rd <= 63'(rd_sh - {1'b0, g});
          qd <= {qd[61:0], 1'b1};
        end else begin
          rd <= rd_sh[62:0];
          qd <= {qd[61:0], 1'b0};
        end
        bit_i <= bit_i - 6'd1;
        if (bit_i == 6'd0) res <= fin;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/rar_checker.sv -----
//------------------------------------------------------------------------------
// Rational arithmetic port checker
// Watches the top level's ports for result consistency and stalls.
//------------------------------------------------------------------------------
`default_nettype none
module rar_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [71:0]  m_axis_tdata
);

  // hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[64:63] != 2'd0 |-> m_axis_tdata[62:0] == '0)
    else $error("error result with nonzero fields");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[64:63] == 2'd0 |-> m_axis_tdata[62:32] != '0)
    else $error("ok result with zero denominator");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[64:63] != 2'd3)
    else $error("undefined status");

  // the front end drops its ready once it has taken a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after accept");

endmodule

bind rational_arith_reduce_top rar_checker u_checker (
  .clk, .rst, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

// ----- tb/testbench.sv -----
//------------------------------------------------------------------------------
// Rational arithmetic reduction testbench
// Drives fraction pairs and operations into the stream input, predicts the
// reduced result of each word and checks the output stream in order, under
// several idling mixes and one long output hold-off.
//------------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0]      num;
    logic [30:0]      den;
    rar_pkg::status_t st;
  } frac_res_t;

  typedef struct {
    rar_pkg::action_t act;
    logic [31:0]      an;
    logic [30:0]      ad;
    logic [31:0]      bn;
    logic [30:0]      bd;
    logic             known;
    frac_res_t        res;
  } stim_row_t;

  localparam frac_res_t NO_RES = '{num: 32'd0, den: 31'd0, st: rar_pkg::ST_OK};

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;

  rational_arith_reduce_top uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  frac_res_t   pending_results[$];
  int          errors;
  int          words_in;
  int          words_out;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_off;
  int          hold_cycles;
  bit          done;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] gcd_u64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // predict the reduced fraction for one operation
  function automatic frac_res_t reduce_fraction(rar_pkg::action_t act, logic [31:0] an,
      logic [30:0] ad, logic [31:0] bn, logic [30:0] bd);
    frac_res_t   r;
    logic signed [63:0] san, sbn, sad, sbd, num, den;
    logic [63:0] mn, md, g;
    logic        neg;
    san = {{32{an[31]}}, an};
    sbn = {{32{bn[31]}}, bn};
    sad = {33'd0, ad};
    sbd = {33'd0, bd};
    r = '{num: 32'd0, den: 31'd0, st: rar_pkg::ST_ZERO};
    if (ad == 0 || bd == 0 || (act == rar_pkg::ACT_DIV && bn == 0)) return r;
    case (act)
      rar_pkg::ACT_ADD: begin num = san * sbd + sbn * sad; den = sad * sbd; end
      rar_pkg::ACT_SUB: begin num = san * sbd - sbn * sad; den = sad * sbd; end
      rar_pkg::ACT_MUL: begin num = san * sbn;             den = sad * sbd; end
      default:          begin num = san * sbd;             den = sad * sbn; end
    endcase
    neg = (num < 0) ^ (den < 0);
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    if (mn == 0) begin
      r = '{num: 32'd0, den: 31'd1, st: rar_pkg::ST_OK};
      return r;
    end
    g = gcd_u64(mn, md);
    mn = mn / g;
    md = md / g;
    r.st = rar_pkg::ST_RANGE;
    if (md > 64'h7FFF_FFFF) return r;
    if (neg ? (mn > 64'h8000_0000) : (mn > 64'h7FFF_FFFF)) return r;
    r.num = neg ? 32'(-mn) : mn[31:0];
    r.den = md[30:0];
    r.st  = rar_pkg::ST_OK;
    return r;
  endfunction

  task automatic send_fraction_op(rar_pkg::action_t act, logic [31:0] an, logic [30:0] ad,
      logic [31:0] bn, logic [30:0] bd, logic known, frac_res_t res);
    frac_res_t want;
    want = known ? res : reduce_fraction(act, an, ad, bn, bd);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  <= {bd, bn, ad, an, act};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_results.push_back(want);
    words_in++;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_num(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(200)) - 100);
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(1 << 16)) - (1 << 15));
    endcase
  endfunction

  function automatic logic [30:0] rand_den(int mode);
    case (mode)
      0: return 31'($urandom);
      1: return 31'($urandom_range(60));
      2: return $urandom_range(1) ? 31'h7FFF_FFFF : 31'd1;
      default: return 31'($urandom_range(1 << 16));
    endcase
  endfunction

  task automatic wait_drained;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  // output side: stall at random, or hold for a long stretch
  always @(negedge clk) begin
    if (hold_off && hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    frac_res_t got, want;
    if (!rst) begin
      cycles <= cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got.num = m_axis_tdata[31:0];
        got.den = m_axis_tdata[62:32];
        got.st  = rar_pkg::status_t'(m_axis_tdata[64:63]);
        words_out <= words_out + 1;
        if (pending_results.size() == 0) begin
          $display("%0t: expected no word, got %h", $time, got);
          errors <= errors + 1;
        end else begin
          want = pending_results.pop_front();
          if (got.num !== want.num || got.den !== want.den || got.st !== want.st) begin
            $display("%0t: expected num %0d den %0d status %0d, got num %0d den %0d status %0d",
              $time, $signed(want.num), want.den, want.st,
              $signed(got.num), got.den, got.st);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  initial begin
    if (!done) begin
      wait (cycles > 2_000_000);
      $display("timeout after %0d cycles", cycles);
      $display("FAIL rational_arith_reduce_top");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    int        phase;
    int        i;
    int        mode;
    stim_row_t row;
    errors = 0; words_in = 0; words_out = 0; cycles = 0; done = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0; hold_cycles = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table: known results typed where obvious
    rows = '{
      '{rar_pkg::ACT_ADD, 32'd1, 31'd0, 32'd1, 31'd1, 1'b1,
        '{32'd0, 31'd0, rar_pkg::ST_ZERO}},
      '{rar_pkg::ACT_MUL, 32'd1, 31'd1, 32'd1, 31'd0, 1'b1,
        '{32'd0, 31'd0, rar_pkg::ST_ZERO}},
      '{rar_pkg::ACT_DIV, 32'd5, 31'd3, 32'd0, 31'd7, 1'b1,
        '{32'd0, 31'd0, rar_pkg::ST_ZERO}},
      '{rar_pkg::ACT_SUB, 32'd3, 31'd4, 32'd3, 31'd4, 1'b1,
        '{32'd0, 31'd1, rar_pkg::ST_OK}},
      '{rar_pkg::ACT_ADD, 32'd1, 31'd2, 32'd1, 31'd2, 1'b1,
        '{32'd1, 31'd1, rar_pkg::ST_OK}},
      '{rar_pkg::ACT_MUL, 32'd2, 31'd3, 32'd3, 31'd4, 1'b1,
        '{32'd1, 31'd2, rar_pkg::ST_OK}},
      '{rar_pkg::ACT_DIV, 32'd1, 31'd2, -32'sd1, 31'd4, 1'b1,
        '{-32'sd2, 31'd1, rar_pkg::ST_OK}},
      '{rar_pkg::ACT_MUL, 32'h7FFF_FFFF, 31'd1, 32'd2, 31'd1, 1'b1,
        '{32'd0, 31'd0, rar_pkg::ST_RANGE}},
      '{rar_pkg::ACT_MUL, 32'h8000_0000, 31'd1, 32'd1, 31'd1, 1'b1,
        '{32'h8000_0000, 31'd1, rar_pkg::ST_OK}},
      '{rar_pkg::ACT_MUL, 32'h8000_0000, 31'd1, -32'sd1, 31'd1, 1'b1,
        '{32'd0, 31'd0, rar_pkg::ST_RANGE}},
      '{rar_pkg::ACT_MUL, 32'd1, 31'h7FFF_FFFF, 32'd1, 31'd2, 1'b1,
        '{32'd0, 31'd0, rar_pkg::ST_RANGE}},
      '{rar_pkg::ACT_ADD, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFE,
        1'b0, NO_RES},
      '{rar_pkg::ACT_SUB, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
        1'b0, NO_RES},
      '{rar_pkg::ACT_DIV, 32'h8000_0000, 31'd3, 32'h8000_0000, 31'd5, 1'b0, NO_RES},
      '{rar_pkg::ACT_DIV, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 31'd1,
        1'b0, NO_RES},
      '{rar_pkg::ACT_ADD, 32'hFFFF_FFFF, 31'd6, 32'd5, 31'd10, 1'b0, NO_RES},
      '{rar_pkg::ACT_SUB, 32'd12345, 31'd777, 32'hFFFF_0000, 31'd65536, 1'b0, NO_RES},
      '{rar_pkg::ACT_DIV, 32'd7, 31'd9, 32'hFFFF_FFF1, 31'd3, 1'b0, NO_RES}
    };
    foreach (rows[k]) begin
      row = rows[k];
      send_fraction_op(row.act, row.an, row.ad, row.bn, row.bd, row.known, row.res);
    end
    wait_drained();

    // long output hold-off while input keeps coming
    hold_cycles = 2000;
    hold_off = 1;
    for (i = 0; i < 8; i++)
      send_fraction_op(rar_pkg::action_t'($urandom_range(3)), rand_num(1),
        rand_den(1) | 31'd1, rand_num(1), rand_den(1) | 31'd1, 1'b0, NO_RES);
    wait_drained();
    hold_off = 0;

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      for (i = 0; i < 500; i++) begin
        mode = $urandom_range(3);
        send_fraction_op(rar_pkg::action_t'($urandom_range(3)), rand_num(mode),
          rand_den($urandom_range(99) < 3 ? 1 : mode), rand_num($urandom_range(3)),
          rand_den($urandom_range(3)), 1'b0, NO_RES);
      end
      wait_drained();
    end

    done = 1;
    $display("covered %0d words in, %0d results out over four idling mixes", words_in,
      words_out);
    $display("zero denominators, division by zero, range overflow and random operands");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("PASS rational_arith_reduce_top");
    end else begin
      $display("FAIL rational_arith_reduce_top");
    end
    $finish;
  end

endmodule
